[hdl/sprite_rle_line_decoder_unit_macros.svh]
// assertion helpers for the sprite line decoder
`ifndef SPRITE_RLE_LINE_DECODER_UNIT_MACROS_SVH
`define SPRITE_RLE_LINE_DECODER_UNIT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define SRLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while in reset
`define SRLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/srld_pkg.sv]
`timescale 1ns / 1ps

package srld_pkg;

    localparam int MAX_LINE_WIDTH  = 4096;
    localparam int PAL_ENTRIES     = 256;
    localparam int PAL_ADDR_W      = $clog2(PAL_ENTRIES);
    localparam int PIX_W           = 24;
    localparam int LEN_W           = 13;
    localparam int BYTE_W          = 8;
    localparam int BYTES_LEFT_W    = 9;
    localparam int QDEPTH          = 4;
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int QCNT_W          = QPTR_W + 1;
    localparam int CFG_IDX_W       = 1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_WIDTH = 2'd1;
    localparam logic [1:0] ERR_BYTES = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_COLOUR = 1'd1;

    localparam logic [LEN_W-1:0] MAX_WIDTH_L = LEN_W'(MAX_LINE_WIDTH);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRANS,
        PH_OLEN,
        PH_INDEX
    } t_phase;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  line_width;
        logic [BYTE_W-1:0] pal_red;
        logic [BYTE_W-1:0] pal_green;
        logic [BYTE_W-1:0] pal_blue;
    } t_in_item;

    typedef struct packed {
        logic [LEN_W-1:0] run_length;
        logic             is_transparent;
        logic [PIX_W-1:0] pixel_value;
        logic [1:0]       error_code;
        logic             line_done;
    } t_out_item;

    // per-item result descriptor, palette data joins one stage later
    typedef struct packed {
        logic             vld;
        t_out_item        a;
        logic             a_use_pal;
        logic             two;
        t_out_item        b;
    } t_desc;

    typedef struct packed {
        logic                  p_vld;
        logic [QCNT_W-1:0]     count;
    } t_q_status;

endpackage

[hdl/srld_in_if.sv]
`timescale 1ns / 1ps

interface srld_in_if;
    logic               valid;
    logic               ready;
    srld_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/srld_out_if.sv]
`timescale 1ns / 1ps

interface srld_out_if;
    logic                valid;
    logic                ready;
    srld_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/srld_ram.sv]
`timescale 1ns / 1ps

module srld_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/srld_decode.sv]
`timescale 1ns / 1ps

module srld_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  srld_pkg::t_in_item                  i_item,
    input  logic                                i_cfg_we,
    input  logic [srld_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [srld_pkg::PIX_W-1:0]          i_cfg_wdata,
    output srld_pkg::t_desc                     o_desc,
    output logic                                o_pal_we,
    output logic [srld_pkg::PAL_ADDR_W-1:0]     o_pal_waddr,
    output logic [srld_pkg::PIX_W-1:0]          o_pal_wdata,
    output logic                                o_pal_re,
    output logic [srld_pkg::PAL_ADDR_W-1:0]     o_pal_raddr
);

    srld_pkg::t_phase                          r_phase, n_phase;
    logic [srld_pkg::BYTES_LEFT_W-1:0]         r_bytes_left, n_bytes_left;
    logic [srld_pkg::LEN_W-1:0]                r_width_left, n_width_left;
    logic [srld_pkg::BYTE_W-1:0]               r_opaque_left, n_opaque_left;
    logic                                      r_output_mode;
    logic [srld_pkg::PIX_W-1:0]                r_trans_colour;

    logic [srld_pkg::LEN_W-1:0]                w_sat;
    logic [srld_pkg::LEN_W-1:0]                b_len;
    logic [srld_pkg::BYTES_LEFT_W-1:0]         b_plus1;
    logic [srld_pkg::PIX_W-1:0]                trans_pix;
    logic                                      is_data;
    logic                                      width_over;
    logic                                      bytes_over;
    logic [srld_pkg::LEN_W-1:0]                nw;
    logic [srld_pkg::BYTES_LEFT_W-1:0]         nb_trans;
    logic [srld_pkg::BYTES_LEFT_W-1:0]         nb_olen;
    logic [srld_pkg::BYTE_W-1:0]               nop;

    assign w_sat      = (i_item.line_width > srld_pkg::MAX_WIDTH_L) ?
                        srld_pkg::MAX_WIDTH_L : i_item.line_width;
    assign b_len      = srld_pkg::LEN_W'(i_item.data_byte);
    assign b_plus1    = srld_pkg::BYTES_LEFT_W'(i_item.data_byte) + 1'b1;
    assign trans_pix  = r_output_mode ? '0 : r_trans_colour;
    assign is_data    = (i_item.cmd == srld_pkg::CMD_DATA) && (r_phase != srld_pkg::PH_IDLE);
    assign width_over = b_len > r_width_left;
    assign bytes_over = b_plus1 > r_bytes_left;
    assign nw         = r_width_left - b_len;
    assign nb_trans   = r_bytes_left - 1'b1;
    assign nb_olen    = r_bytes_left - b_plus1;
    assign nop        = (r_opaque_left != '0) ? r_opaque_left - 1'b1 : r_opaque_left;

    // result that may close the line, with a fill in colour mode
    function automatic srld_pkg::t_desc finish_line(
        input logic [srld_pkg::BYTES_LEFT_W-1:0] nb,
        input logic [srld_pkg::LEN_W-1:0]        wl,
        input srld_pkg::t_out_item               a,
        input logic                              use_pal,
        input logic                              mode,
        input logic [srld_pkg::PIX_W-1:0]        colour
    );
        srld_pkg::t_desc d;
        d           = '0;
        d.vld       = 1'b1;
        d.a         = a;
        d.a_use_pal = use_pal;
        if (nb == '0) begin
            if (!mode && wl != '0) begin
                d.two              = 1'b1;
                d.b.run_length     = wl;
                d.b.is_transparent = 1'b1;
                d.b.pixel_value    = colour;
                d.b.error_code     = srld_pkg::ERR_OK;
                d.b.line_done      = 1'b1;
            end else begin
                d.a.line_done = 1'b1;
            end
        end
        return d;
    endfunction

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_bytes_left  = r_bytes_left;
        n_width_left  = r_width_left;
        n_opaque_left = r_opaque_left;
        if (i_item.cmd == srld_pkg::CMD_START) begin
            n_opaque_left = '0;
            if (i_item.data_byte == '0) begin
                n_phase      = srld_pkg::PH_IDLE;
                n_bytes_left = '0;
                n_width_left = '0;
            end else begin
                n_phase      = srld_pkg::PH_TRANS;
                n_bytes_left = srld_pkg::BYTES_LEFT_W'(i_item.data_byte);
                n_width_left = w_sat;
            end
        end else if (is_data) begin
            case (r_phase)
                srld_pkg::PH_TRANS: begin
                    if (width_over) begin
                        n_phase = srld_pkg::PH_IDLE;
                    end else begin
                        n_width_left = nw;
                        n_bytes_left = nb_trans;
                        n_phase      = (nb_trans == '0) ? srld_pkg::PH_IDLE : srld_pkg::PH_OLEN;
                    end
                end
                srld_pkg::PH_OLEN: begin
                    if (width_over || bytes_over) begin
                        n_phase = srld_pkg::PH_IDLE;
                    end else begin
                        n_width_left = nw;
                        n_bytes_left = nb_olen;
                        if (i_item.data_byte != '0) begin
                            n_opaque_left = i_item.data_byte;
                            n_phase       = srld_pkg::PH_INDEX;
                        end else if (nb_olen != '0) begin
                            n_phase = srld_pkg::PH_TRANS;
                        end else begin
                            n_phase = srld_pkg::PH_IDLE;
                        end
                    end
                end
                srld_pkg::PH_INDEX: begin
                    n_opaque_left = nop;
                    if (nop == '0) begin
                        n_phase = (r_bytes_left == '0) ? srld_pkg::PH_IDLE : srld_pkg::PH_TRANS;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // result descriptor
    always_comb begin
        srld_pkg::t_out_item a;
        a                = '0;
        o_desc           = '0;
        if (i_item.cmd == srld_pkg::CMD_START) begin
            if (i_item.data_byte == '0) begin
                o_desc.vld                = 1'b1;
                o_desc.a.run_length       = w_sat;
                o_desc.a.is_transparent   = 1'b1;
                o_desc.a.pixel_value      = trans_pix;
                o_desc.a.line_done        = 1'b1;
            end
        end else if (is_data) begin
            case (r_phase)
                srld_pkg::PH_TRANS: begin
                    if (width_over) begin
                        o_desc.vld          = 1'b1;
                        o_desc.a.error_code = srld_pkg::ERR_WIDTH;
                        o_desc.a.line_done  = 1'b1;
                    end else begin
                        a.run_length     = b_len;
                        a.is_transparent = 1'b1;
                        a.pixel_value    = trans_pix;
                        o_desc = finish_line(nb_trans, nw, a, 1'b0, r_output_mode,
                                             r_trans_colour);
                    end
                end
                srld_pkg::PH_OLEN: begin
                    if (width_over || bytes_over) begin
                        o_desc.vld          = 1'b1;
                        o_desc.a.error_code = width_over ? srld_pkg::ERR_WIDTH :
                                                           srld_pkg::ERR_BYTES;
                        o_desc.a.line_done  = 1'b1;
                    end else if (i_item.data_byte == '0 && nb_olen == '0) begin
                        o_desc.vld              = 1'b1;
                        o_desc.a.run_length     = r_output_mode ? '0 : nw;
                        o_desc.a.is_transparent = 1'b1;
                        o_desc.a.pixel_value    = trans_pix;
                        o_desc.a.line_done      = 1'b1;
                    end
                end
                srld_pkg::PH_INDEX: begin
                    a.run_length  = srld_pkg::LEN_W'(1);
                    a.pixel_value = srld_pkg::PIX_W'(i_item.data_byte);
                    if (nop != '0) begin
                        o_desc.vld       = 1'b1;
                        o_desc.a         = a;
                        o_desc.a_use_pal = !r_output_mode;
                    end else begin
                        o_desc = finish_line(r_bytes_left, r_width_left, a, !r_output_mode,
                                             r_output_mode, r_trans_colour);
                    end
                end
                default: begin
                    o_desc = '0;
                end
            endcase
        end
    end

    assign o_pal_we    = i_accept && (i_item.cmd == srld_pkg::CMD_LOAD);
    assign o_pal_waddr = i_item.data_byte;
    assign o_pal_wdata = {i_item.pal_red[5:0], 2'b00,
                          i_item.pal_green[5:0], 2'b00,
                          i_item.pal_blue[5:0], 2'b00};
    assign o_pal_re    = i_accept && is_data && (r_phase == srld_pkg::PH_INDEX);
    assign o_pal_raddr = i_item.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= srld_pkg::PH_IDLE;
            r_bytes_left   <= '0;
            r_width_left   <= '0;
            r_opaque_left  <= '0;
            r_output_mode  <= 1'b0;
            r_trans_colour <= '0;
        end else begin
            if (i_accept) begin
                r_phase       <= n_phase;
                r_bytes_left  <= n_bytes_left;
                r_width_left  <= n_width_left;
                r_opaque_left <= n_opaque_left;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    srld_pkg::CFG_OUTPUT_MODE:  r_output_mode  <= i_cfg_wdata[0];
                    srld_pkg::CFG_TRANS_COLOUR: r_trans_colour <= i_cfg_wdata;
                    default:                    r_output_mode  <= r_output_mode;
                endcase
            end
        end
    end

endmodule

[hdl/srld_out_queue.sv]
`timescale 1ns / 1ps

module srld_out_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  srld_pkg::t_desc               i_desc,
    input  logic [srld_pkg::PIX_W-1:0]    i_pal_rdata,
    output logic                          o_in_ready,
    output srld_pkg::t_q_status           o_status,
    srld_out_if.source                    o_out
);

    srld_pkg::t_desc                 r_p;
    logic                            r_p_vld;
    srld_pkg::t_out_item             r_fifo [srld_pkg::QDEPTH];
    logic [srld_pkg::QPTR_W-1:0]     r_wp, r_rp;
    logic [srld_pkg::QCNT_W-1:0]     r_count, n_count;
    logic                            adv;
    logic                            pop;
    logic [srld_pkg::QCNT_W-1:0]     push_n;
    srld_pkg::t_out_item             res_a;

    // stage drains only with room for a two-result item
    assign adv        = r_p_vld && (r_count <= srld_pkg::QCNT_W'(srld_pkg::QDEPTH - 2));
    assign o_in_ready = !r_p_vld || adv;
    assign pop        = o_out.valid && o_out.ready;
    assign push_n     = adv ? (r_p.two ? srld_pkg::QCNT_W'(2) : srld_pkg::QCNT_W'(1)) : '0;
    assign n_count    = r_count + push_n - srld_pkg::QCNT_W'(pop);

    always_comb begin
        res_a = r_p.a;
        if (r_p.a_use_pal) begin
            res_a.pixel_value = i_pal_rdata;
        end
    end

    assign o_out.valid = r_count != '0;
    assign o_out.data  = r_fifo[r_rp];

    assign o_status.p_vld = r_p_vld;
    assign o_status.count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_accept) begin
                r_p_vld <= i_desc.vld;
            end else if (adv) begin
                r_p_vld <= 1'b0;
            end
            r_wp    <= r_wp + push_n[srld_pkg::QPTR_W-1:0];
            r_rp    <= r_rp + srld_pkg::QPTR_W'(pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p <= i_desc;
        end
        if (adv) begin
            r_fifo[r_wp] <= res_a;
            if (r_p.two) begin
                r_fifo[r_wp + 1'b1] <= r_p.b;
            end
        end
    end

endmodule

[hdl/sprite_rle_line_decoder_unit.sv]
// an accepted transaction is registered in the result stage with its palette read, then written into the result queue
// throughput: one transaction per cycle while the result queue has room; an item with a trailing fill gives two results
// palette lookups go through a 256 x 24 synchronous ram, one read and one write per cycle
// reset (synchronous, active low) clears line state, config registers and the result queue
// palette contents are not cleared by reset
`timescale 1ns / 1ps
`include "sprite_rle_line_decoder_unit_macros.svh"

module sprite_rle_line_decoder_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    srld_in_if.sink                           i_in,
    srld_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [srld_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [srld_pkg::PIX_W-1:0]        i_cfg_wdata
);

    logic                                 in_ready;
    logic                                 accept;
    srld_pkg::t_desc                      desc;
    srld_pkg::t_q_status                  q_status;
    logic                                 pal_we;
    logic [srld_pkg::PAL_ADDR_W-1:0]      pal_waddr;
    logic [srld_pkg::PIX_W-1:0]           pal_wdata;
    logic                                 pal_re;
    logic [srld_pkg::PAL_ADDR_W-1:0]      pal_raddr;
    logic [srld_pkg::PIX_W-1:0]           pal_rdata;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    srld_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_desc      (desc),
        .o_pal_we    (pal_we),
        .o_pal_waddr (pal_waddr),
        .o_pal_wdata (pal_wdata),
        .o_pal_re    (pal_re),
        .o_pal_raddr (pal_raddr)
    );

    srld_ram #(
        .WIDTH (srld_pkg::PIX_W),
        .DEPTH (srld_pkg::PAL_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wdata),
        .i_re    (pal_re),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    srld_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_desc      (desc),
        .i_pal_rdata (pal_rdata),
        .o_in_ready  (in_ready),
        .o_status    (q_status),
        .o_out       (o_out)
    );

    `SRLD_ASSERT_NOW(a_queue_bound, 1'b1, q_status.count <= srld_pkg::QCNT_W'(srld_pkg::QDEPTH), "result queue overflow")
    `SRLD_ASSERT_NEXT(a_stage_load, accept, q_status.p_vld == $past(desc.vld), "result stage not loaded on accept")
    `SRLD_ASSERT_NOW(a_err_shape, o_out.valid && o_out.data.error_code != srld_pkg::ERR_OK, o_out.data.line_done && o_out.data.run_length == '0, "error result malformed")
    `SRLD_ASSERT_NOW(a_stall, q_status.p_vld && q_status.count > srld_pkg::QCNT_W'(srld_pkg::QDEPTH - 2), !i_in.ready, "input taken with no room for results")

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import srld_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int RESET_CYCLES  = 12;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [PIX_W-1:0]     cfg_wdata;

    srld_in_if  in_if();
    srld_out_if out_if();

    sprite_rle_line_decoder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // decoder state as seen by the predictor
    logic [PIX_W-1:0]        pal_mem [PAL_ENTRIES];
    t_phase                  ph;
    logic [BYTES_LEFT_W-1:0] bytes_rem;
    logic [LEN_W-1:0]        wid_rem;
    logic [BYTE_W-1:0]       opq_rem;
    logic                    raw_mode;
    logic [PIX_W-1:0]        skip_rgb;

    t_out_item pending_pixels[$];
    t_in_item  plan[$];

    int errors = 0;
    int cycles = 0;
    int burst_left;
    int gap_left;
    int max_burst;
    int max_gap;
    int hold_asked;
    int hold_given = 0;
    int hold_left = 0;
    int pattern_left = 0;
    int stall_pct = 0;

    function automatic int lesser(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] skip_value();
        return raw_mode ? PIX_W'(0) : skip_rgb;
    endfunction

    task automatic emit(input logic [LEN_W-1:0] len, input logic trans,
                        input logic [PIX_W-1:0] pix, input logic [1:0] err,
                        input logic done);
        t_out_item r;
        r.run_length     = len;
        r.is_transparent = trans;
        r.pixel_value    = pix;
        r.error_code     = err;
        r.line_done      = done;
        pending_pixels.push_back(r);
    endtask

    // result that may close the line, plus the trailing fill in colour mode
    task automatic end_or_continue(input logic [LEN_W-1:0] len, input logic trans,
                                   input logic [PIX_W-1:0] pix);
        if (bytes_rem != 0) begin
            emit(len, trans, pix, ERR_OK, 1'b0);
        end else begin
            ph = PH_IDLE;
            if (!raw_mode && wid_rem != 0) begin
                emit(len, trans, pix, ERR_OK, 1'b0);
                emit(wid_rem, 1'b1, skip_rgb, ERR_OK, 1'b1);
            end else begin
                emit(len, trans, pix, ERR_OK, 1'b1);
            end
        end
    endtask

    task automatic abort_line(input logic [1:0] code);
        ph = PH_IDLE;
        emit(LEN_W'(0), 1'b0, PIX_W'(0), code, 1'b1);
    endtask

    task automatic decode_item(input t_in_item it);
        logic [LEN_W-1:0]  w;
        logic [PIX_W-1:0]  pix;
        logic [BYTE_W-1:0] b;
        b = it.data_byte;
        case (it.cmd)
            CMD_LOAD: begin
                pal_mem[b] = {it.pal_red[5:0], 2'b00, it.pal_green[5:0], 2'b00,
                              it.pal_blue[5:0], 2'b00};
            end
            CMD_START: begin
                w = (it.line_width > MAX_WIDTH_L) ? MAX_WIDTH_L : it.line_width;
                opq_rem = '0;
                if (b == 0) begin
                    ph        = PH_IDLE;
                    bytes_rem = '0;
                    wid_rem   = '0;
                    emit(w, 1'b1, skip_value(), ERR_OK, 1'b1);
                end else begin
                    bytes_rem = BYTES_LEFT_W'(b);
                    wid_rem   = w;
                    ph        = PH_TRANS;
                end
            end
            CMD_DATA: begin
                case (ph)
                    PH_TRANS: begin
                        if (LEN_W'(b) > wid_rem) begin
                            abort_line(ERR_WIDTH);
                        end else begin
                            wid_rem   = wid_rem - LEN_W'(b);
                            bytes_rem = bytes_rem - 1'b1;
                            ph        = PH_OLEN;
                            end_or_continue(LEN_W'(b), 1'b1, skip_value());
                        end
                    end
                    PH_OLEN: begin
                        if (LEN_W'(b) > wid_rem) begin
                            abort_line(ERR_WIDTH);
                        end else if (int'(b) + 1 > int'(bytes_rem)) begin
                            abort_line(ERR_BYTES);
                        end else begin
                            wid_rem   = wid_rem - LEN_W'(b);
                            bytes_rem = bytes_rem - BYTES_LEFT_W'(b) - 1'b1;
                            if (b != 0) begin
                                opq_rem = b;
                                ph      = PH_INDEX;
                            end else if (bytes_rem != 0) begin
                                ph = PH_TRANS;
                            end else begin
                                ph = PH_IDLE;
                                emit(raw_mode ? LEN_W'(0) : wid_rem, 1'b1, skip_value(),
                                     ERR_OK, 1'b1);
                            end
                        end
                    end
                    PH_INDEX: begin
                        pix = raw_mode ? PIX_W'(b) : pal_mem[b];
                        if (opq_rem != 0) opq_rem = opq_rem - 1'b1;
                        if (opq_rem != 0) begin
                            emit(LEN_W'(1), 1'b0, pix, ERR_OK, 1'b0);
                        end else begin
                            ph = PH_TRANS;
                            end_or_continue(LEN_W'(1), 1'b0, pix);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    // one transaction on the input channel, bursts and gaps decided here
    task automatic send_item(input t_in_item it, input bit more);
        if (gap_left > 0) begin
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        decode_item(it);
        if (!more) begin
            in_if.valid <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, max_burst);
            gap_left = (max_gap == 0 || $urandom_range(0, 3) == 0) ? 0
                                                                  : $urandom_range(1, max_gap);
            if (gap_left > 0) in_if.valid <= 1'b0;
        end
    endtask

    task automatic run_plan();
        foreach (plan[i]) send_item(plan[i], i != plan.size() - 1);
        plan.delete();
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_registers(input logic mode, input logic [PIX_W-1:0] colour);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_OUTPUT_MODE;
        cfg_wdata <= PIX_W'(mode);
        @(posedge i_clk);
        raw_mode = mode;
        cfg_idx   <= CFG_TRANS_COLOUR;
        cfg_wdata <= colour;
        @(posedge i_clk);
        skip_rgb = colour;
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic [1:0] cmd, input logic [7:0] b,
                                           input logic [LEN_W-1:0] w);
        t_in_item it;
        it            = '0;
        it.cmd        = cmd;
        it.data_byte  = b;
        it.line_width = w;
        return it;
    endfunction

    function automatic t_in_item make_load(input logic [7:0] entry, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] bl);
        t_in_item it;
        it           = make_item(CMD_LOAD, entry, LEN_W'($urandom_range(0, 8191)));
        it.pal_red   = r;
        it.pal_green = g;
        it.pal_blue  = bl;
        return it;
    endfunction

    function automatic t_in_item random_fields(input logic [1:0] cmd, input logic [7:0] b);
        t_in_item it;
        it           = make_item(cmd, b, LEN_W'($urandom_range(0, 8191)));
        it.pal_red   = BYTE_W'($urandom_range(0, 255));
        it.pal_green = BYTE_W'($urandom_range(0, 255));
        it.pal_blue  = BYTE_W'($urandom_range(0, 255));
        return it;
    endfunction

    // a sprite line, well formed unless broken is set
    task automatic build_line(input bit broken);
        logic [BYTE_W-1:0] seq_bytes[$];
        t_in_item          it;
        int                w;
        int                wrem;
        int                t;
        int                n;
        int                cnt;
        if ($urandom_range(0, 9) == 0) w = $urandom_range(3000, 8191);
        else w = $urandom_range(0, 90);
        wrem = (w > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : w;
        if ($urandom_range(0, 14) != 0) begin
            do begin
                t = $urandom_range(0, lesser(wrem, 255));
                if ($urandom_range(0, 1) == 0) t = t / 4;
                seq_bytes.push_back(BYTE_W'(t));
                wrem -= t;
                if (seq_bytes.size() > 252 || $urandom_range(0, 5) == 0) break;
                n = $urandom_range(0, lesser(lesser(wrem, 254 - seq_bytes.size()),
                                             ($urandom_range(0, 3) == 0) ? 60 : 6));
                seq_bytes.push_back(BYTE_W'(n));
                wrem -= n;
                repeat (n) seq_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            end while (seq_bytes.size() <= 252 && $urandom_range(0, 3) != 0);
        end
        cnt = seq_bytes.size();
        if (broken) begin
            case ($urandom_range(0, 4))
                0: cnt = $urandom_range(1, 255);
                1: w = $urandom_range(0, w);
                2: if (seq_bytes.size() > 0)
                       repeat ($urandom_range(1, seq_bytes.size())) void'(seq_bytes.pop_back());
                3: if (seq_bytes.size() > 0)
                       seq_bytes[$urandom_range(0, seq_bytes.size() - 1)] =
                           BYTE_W'($urandom_range(0, 255));
                default: seq_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            endcase
        end
        it            = random_fields(CMD_START, BYTE_W'(cnt));
        it.line_width = LEN_W'(w);
        plan.push_back(it);
        foreach (seq_bytes[k]) begin
            if ($urandom_range(0, 29) == 0)
                plan.push_back(random_fields(CMD_LOAD, BYTE_W'($urandom_range(0, 255))));
            plan.push_back(random_fields(CMD_DATA, seq_bytes[k]));
        end
    endtask

    task automatic random_traffic(input int n);
        int r;
        while (plan.size() < n) begin
            r = $urandom_range(0, 99);
            if (r < 80) build_line(1'b0);
            else if (r < 92) build_line(1'b1);
            else plan.push_back(random_fields(2'($urandom_range(0, 3)),
                                              BYTE_W'($urandom_range(0, 255))));
        end
        run_plan();
    endtask

    task automatic test_palette_fill();
        max_burst = 20;
        max_gap   = 3;
        for (int e = 0; e < PAL_ENTRIES; e++)
            plan.push_back(make_load(BYTE_W'(e), BYTE_W'($urandom_range(0, 255)),
                                     BYTE_W'($urandom_range(0, 255)),
                                     BYTE_W'($urandom_range(0, 255))));
        run_plan();
        wait_drained();
    endtask

    task automatic test_colour_corner_cases();
        set_registers(1'b0, 24'h5A3C96);
        plan.push_back(make_item(CMD_START, 8'd0, 13'd0));
        plan.push_back(make_item(CMD_START, 8'd0, 13'd4096));
        plan.push_back(make_item(CMD_START, 8'd0, 13'h1FFF));
        // width exceeded on the second transparent run
        plan.push_back(make_item(CMD_START, 8'd5, 13'd20));
        plan.push_back(make_item(CMD_DATA, 8'd3, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd2, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd0, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd255, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd255, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd9, 13'd0));
        plan.push_back(make_item(CMD_NONE, 8'hFF, 13'h1FFF));
        // byte count exceeded
        plan.push_back(make_item(CMD_START, 8'd2, 13'd100));
        plan.push_back(make_item(CMD_DATA, 8'd1, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd5, 13'd0));
        // ends on zero opaque length
        plan.push_back(make_item(CMD_START, 8'd2, 13'd50));
        plan.push_back(make_item(CMD_DATA, 8'd4, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd0, 13'd0));
        // ends on a transparent run, with and without fill
        plan.push_back(make_item(CMD_START, 8'd1, 13'd30));
        plan.push_back(make_item(CMD_DATA, 8'd10, 13'd0));
        plan.push_back(make_item(CMD_START, 8'd1, 13'd6));
        plan.push_back(make_item(CMD_DATA, 8'd6, 13'd0));
        // line abandoned by a new start
        plan.push_back(make_item(CMD_START, 8'd3, 13'd40));
        plan.push_back(make_item(CMD_DATA, 8'd2, 13'd0));
        plan.push_back(make_item(CMD_START, 8'd0, 13'd7));
        // palette write inside a line, then lookup of that entry
        plan.push_back(make_item(CMD_START, 8'd3, 13'd10));
        plan.push_back(make_item(CMD_DATA, 8'd0, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd1, 13'd0));
        plan.push_back(make_load(8'd7, 8'hFF, 8'h80, 8'h3F));
        plan.push_back(make_item(CMD_DATA, 8'd7, 13'd0));
        max_burst = 4;
        max_gap   = 2;
        run_plan();
        wait_drained();
    endtask

    task automatic test_raw_corner_cases();
        set_registers(1'b1, 24'hFFFFFF);
        plan.push_back(make_item(CMD_START, 8'd0, 13'd12));
        plan.push_back(make_item(CMD_START, 8'd4, 13'd9));
        plan.push_back(make_item(CMD_DATA, 8'd1, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd2, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'hAA, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'h55, 13'd0));
        plan.push_back(make_item(CMD_START, 8'd2, 13'd20));
        plan.push_back(make_item(CMD_DATA, 8'd3, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd0, 13'd0));
        plan.push_back(make_item(CMD_DATA, 8'd4, 13'd0));
        run_plan();
        wait_drained();
    endtask

    task automatic test_random_phase(input logic mode, input logic [PIX_W-1:0] colour,
                                     input int n, input int burst, input int gap);
        set_registers(mode, colour);
        max_burst = burst;
        max_gap   = gap;
        random_traffic(n);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        set_registers(1'b0, 24'h000000);
        max_burst = 1000;
        max_gap   = 0;
        hold_asked++;
        random_traffic(100);
        wait_drained();
    endtask

    task automatic log_mismatch(input string why, input t_out_item want, input t_out_item got);
        errors++;
        if (errors <= 10)
            $display("%s: expected len=%0d trans=%0b pix=%06h err=%0d done=%0b, got len=%0d trans=%0b pix=%06h err=%0d done=%0b",
                     why, want.run_length, want.is_transparent, want.pixel_value,
                     want.error_code, want.line_done, got.run_length, got.is_transparent,
                     got.pixel_value, got.error_code, got.line_done);
    endtask

    always @(posedge i_clk) begin : result_side
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (pending_pixels.size() == 0) begin
                want = '0;
                log_mismatch("unexpected result", want, got);
            end else begin
                want = pending_pixels.pop_front();
                if (got.run_length !== want.run_length ||
                    got.is_transparent !== want.is_transparent ||
                    got.pixel_value !== want.pixel_value ||
                    got.error_code !== want.error_code ||
                    got.line_done !== want.line_done)
                    log_mismatch("result mismatch", want, got);
            end
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (hold_given != hold_asked) begin
            hold_given = hold_asked;
            hold_left  = LONG_HOLD - 1;
            out_if.ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 200);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 55;
                    default: stall_pct = 85;
                endcase
            end
            pattern_left--;
            out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_wdata    = '0;
        burst_left   = 0;
        gap_left     = 0;
        max_burst    = 8;
        max_gap      = 4;
        hold_asked   = 0;
        ph           = PH_IDLE;
        bytes_rem    = '0;
        wid_rem      = '0;
        opq_rem      = '0;
        raw_mode     = 1'b0;
        skip_rgb     = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_palette_fill();
        test_colour_corner_cases();
        test_raw_corner_cases();
        test_random_phase(1'b0, 24'hFFFFFF, 120, 12, 0);
        test_random_phase(1'b1, PIX_W'($urandom_range(0, 24'hFFFFFF)), 120, 6, 5);
        test_output_backpressure();
        test_random_phase(1'b1, 24'hFFFFFF, 120, 3, 8);
        test_random_phase(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 24'hFFFFFF)),
                          120, 10, 3);
        test_random_phase(1'b0, 24'h000000, 120, 5, 6);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/srld_pkg.sv
hdl/srld_in_if.sv
hdl/srld_out_if.sv
hdl/srld_ram.sv
hdl/srld_decode.sv
hdl/srld_out_queue.sv
hdl/sprite_rle_line_decoder_unit.sv
dv/tb.sv
